/* rtl/touch_button_window_debounce_defines.svh */
// assertion macros for the touch button debounce
`ifndef TOUCH_BUTTON_WINDOW_DEBOUNCE_DEFINES_SVH
`define TOUCH_BUTTON_WINDOW_DEBOUNCE_DEFINES_SVH

// same-cycle implication
`define TBWD_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tbwd assertion failed");

// next-cycle implication
`define TBWD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tbwd assertion failed");

`endif

/* rtl/tbwd_pkg.sv */
package tbwd_pkg;

  localparam int WINDOW_LEN = 5;
  localparam int COUNT_W    = $clog2(WINDOW_LEN + 1);
  localparam int HOLD_W     = $clog2(WINDOW_LEN);
  localparam int THR_W      = 3;
  localparam int CMP_W      = (COUNT_W > THR_W) ? COUNT_W : THR_W;
  localparam int COORD_W    = 10;
  localparam int CFG_IDX_W  = 3;

  localparam logic [COORD_W-1:0] RECT_RIGHT_RST  = COORD_W'(65);
  localparam logic [COORD_W-1:0] RECT_BOTTOM_RST = COORD_W'(65);
  localparam logic [THR_W-1:0]   THRESHOLD_RST   = THR_W'(2);
  localparam logic [HOLD_W-1:0]  HOLD_LOAD       = HOLD_W'(WINDOW_LEN - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_LEFT       = 3'd0,
    REG_RECT_RIGHT      = 3'd1,
    REG_RECT_TOP        = 3'd2,
    REG_RECT_BOTTOM     = 3'd3,
    REG_PRESS_THRESHOLD = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_INITIAL = 2'd0,
    MODE_STOPPED = 2'd1,
    MODE_RESUMED = 2'd2
  } mode_t;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] bottom;
    logic [THR_W-1:0]   threshold;
  } cfg_t;

  typedef struct packed {
    logic step;
    logic hit;
  } vote_ctl_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       fired;
  } vote_res_t;

endpackage

/* rtl/touch_button_window_debounce.sv */
// touch button debounce with a sliding-window majority vote
// input channel: in_valid / in_stall carry one touch sample (touch_x, touch_y)
//   per transfer; a transfer happens on a clock edge with in_valid high and
//   in_stall low
// output channel: out_valid / out_stall carry one result per sample:
//   play_state after the sample, press_fired and hit_now
// configuration: cfg_valid / cfg_ready write the rectangle edges and the
//   press threshold by cfg_index; cfg_ready is always high; the user must
//   make writes only while no sample is in flight; the block does not enforce it
// path: a sample is held in the sample register and then its result in
//   the result register
// throughput: one sample per cycle while out_stall is low, set by the
//   combinational vote over the window register and the hold-off counter
// a stalled result holds; the sample register keeps taking a new sample as
//   long as it is empty or the result register is empty or is being drained,
//   otherwise in_stall rises
// reset: synchronous, clears the hit window, hold-off counter and play state,
//   restores the default rectangle and threshold and empties both registers
module touch_button_window_debounce
  import tbwd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COORD_W-1:0]   touch_x,
  input  logic [COORD_W-1:0]   touch_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           play_state,
  output logic                 press_fired,
  output logic                 hit_now,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  cfg_t      cfg;
  vote_ctl_t ctl;
  vote_res_t res;
  logic      s1_valid;
  logic      hit;
  logic      out_free;
  logic      in_take;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign ctl.step = s1_valid && out_free;
  assign ctl.hit  = hit;

  tbwd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tbwd_hit u_hit (
    .clk     (clk),
    .load    (in_take),
    .touch_x (touch_x),
    .touch_y (touch_y),
    .cfg     (cfg),
    .hit     (hit)
  );

  tbwd_vote u_vote (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .threshold (cfg.threshold),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (ctl.step) begin
        s1_valid <= 1'b0;
      end
      if (ctl.step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      play_state  <= res.mode;
      press_fired <= res.fired;
      hit_now     <= hit;
    end
  end

endmodule

/* rtl/tbwd_cfg.sv */
module tbwd_cfg
  import tbwd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left      <= '0;
      cfg.right     <= RECT_RIGHT_RST;
      cfg.top       <= '0;
      cfg.bottom    <= RECT_BOTTOM_RST;
      cfg.threshold <= THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RECT_LEFT:       cfg.left      <= cfg_data;
        REG_RECT_RIGHT:      cfg.right     <= cfg_data;
        REG_RECT_TOP:        cfg.top       <= cfg_data;
        REG_RECT_BOTTOM:     cfg.bottom    <= cfg_data;
        REG_PRESS_THRESHOLD: cfg.threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/tbwd_hit.sv */
module tbwd_hit
  import tbwd_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic [COORD_W-1:0] touch_x,
  input  logic [COORD_W-1:0] touch_y,
  input  cfg_t               cfg,
  output logic               hit
);

  logic [COORD_W-1:0] x;
  logic [COORD_W-1:0] y;

  // sample register
  always_ff @(posedge clk) begin
    if (load) begin
      x <= touch_x;
      y <= touch_y;
    end
  end

  assign hit = (x > cfg.left) && (x < cfg.right) && (y > cfg.top) && (y < cfg.bottom);

endmodule

/* rtl/tbwd_vote.sv */
`include "touch_button_window_debounce_defines.svh"

module tbwd_vote
  import tbwd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  vote_ctl_t        ctl,
  input  logic [THR_W-1:0] threshold,
  output vote_res_t        res
);

  logic [WINDOW_LEN-1:0] window;
  logic [WINDOW_LEN-1:0] window_next;
  logic [HOLD_W-1:0]     holdoff;
  logic [HOLD_W-1:0]     holdoff_next;
  mode_t                 mode;
  mode_t                 mode_next;
  logic [COUNT_W-1:0]    count;
  logic                  fire;

  // oldest sample drops out as the new one enters
  assign window_next = {window[WINDOW_LEN-2:0], ctl.hit};

  always_comb begin
    count = '0;
    for (int k = 0; k < WINDOW_LEN; k++) begin
      count = count + COUNT_W'(window_next[k]);
    end
  end

  assign fire = (CMP_W'(count) >= CMP_W'(threshold)) && (holdoff == '0);

  always_comb begin
    mode_next = mode;
    if (fire) begin
      unique case (mode)
        MODE_INITIAL: mode_next = MODE_STOPPED;
        MODE_STOPPED: mode_next = MODE_RESUMED;
        MODE_RESUMED: mode_next = MODE_STOPPED;
        default:      mode_next = mode;
      endcase
    end
  end

  always_comb begin
    priority if (fire) begin
      holdoff_next = HOLD_LOAD;
    end else if (holdoff != '0) begin
      holdoff_next = holdoff - HOLD_W'(1);
    end else begin
      holdoff_next = holdoff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window  <= '0;
      holdoff <= '0;
      mode    <= MODE_INITIAL;
    end else if (ctl.step) begin
      window  <= window_next;
      holdoff <= holdoff_next;
      mode    <= mode_next;
    end
  end

  assign res.mode  = mode_next;
  assign res.fired = fire;

  `TBWD_ASSERT_NEXT(a_fire_loads_holdoff, ctl.step && fire, holdoff == HOLD_LOAD)
  `TBWD_ASSERT(a_holdoff_blocks_fire, holdoff != '0, !fire)
  `TBWD_ASSERT(a_mode_reachable, 1'b1, (mode == MODE_INITIAL) || (mode == MODE_STOPPED) || (mode == MODE_RESUMED))
  `TBWD_ASSERT_NEXT(a_idle_keeps_state, !ctl.step, $stable(window) && $stable(holdoff))

endmodule

/* verif/touch_button_window_debounce_tb.sv */
`timescale 1ns / 100ps

module touch_button_window_debounce_tb;
  import tbwd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int COORD_MAX      = (1 << COORD_W) - 1;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } touch_sample_t;

  typedef struct packed {
    mode_t mode;
    logic  fired;
    logic  hit;
  } press_result_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [COORD_W-1:0]   touch_x = '0;
  logic [COORD_W-1:0]   touch_y = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           play_state;
  logic                 press_fired;
  logic                 hit_now;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;

  touch_button_window_debounce dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .touch_x     (touch_x),
    .touch_y     (touch_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .play_state  (play_state),
    .press_fired (press_fired),
    .hit_now     (hit_now),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // predictor state and configuration copy
  logic [COORD_W-1:0]    btn_left   = '0;
  logic [COORD_W-1:0]    btn_right  = RECT_RIGHT_RST;
  logic [COORD_W-1:0]    btn_top    = '0;
  logic [COORD_W-1:0]    btn_bottom = RECT_BOTTOM_RST;
  logic [THR_W-1:0]      press_thr  = THRESHOLD_RST;
  logic [WINDOW_LEN-1:0] vote_window  = '0;
  logic [HOLD_W-1:0]     vote_slot    = '0;
  logic [COUNT_W-1:0]    holdoff_left = '0;
  mode_t                 player_mode  = MODE_INITIAL;

  touch_sample_t touch_pending[$];
  press_result_t expected_presses[$];
  touch_sample_t next_sample;

  bit in_taken       = 1'b0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_queued   = 0;
  int results_seen   = 0;
  int mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic press_result_t predict_press(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y);
    press_result_t r;
    logic [COUNT_W-1:0] votes;
    r.hit = (x > btn_left) && (x < btn_right) && (y > btn_top) && (y < btn_bottom);
    vote_window[vote_slot] = r.hit;
    vote_slot = (vote_slot == HOLD_W'(WINDOW_LEN - 1)) ? '0 : vote_slot + HOLD_W'(1);
    votes = '0;
    for (int k = 0; k < WINDOW_LEN; k++) votes = votes + COUNT_W'(vote_window[k]);
    r.fired = 1'b0;
    if (votes >= press_thr && holdoff_left == '0) begin
      case (player_mode)
        MODE_INITIAL: player_mode = MODE_STOPPED;
        MODE_STOPPED: player_mode = MODE_RESUMED;
        MODE_RESUMED: player_mode = MODE_STOPPED;
        default:      player_mode = player_mode;
      endcase
      holdoff_left = COUNT_W'(WINDOW_LEN);
      r.fired = 1'b1;
    end
    if (holdoff_left != '0) holdoff_left = holdoff_left - COUNT_W'(1);
    r.mode = player_mode;
    return r;
  endfunction

  // sample driver
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (touch_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_sample = touch_pending.pop_front();
        in_valid <= 1'b1;
        touch_x  <= next_sample.x;
        touch_y  <= next_sample.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    press_result_t want;
    in_taken = in_valid && !in_stall;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RECT_LEFT:       btn_left   = cfg_data;
          REG_RECT_RIGHT:      btn_right  = cfg_data;
          REG_RECT_TOP:        btn_top    = cfg_data;
          REG_RECT_BOTTOM:     btn_bottom = cfg_data;
          REG_PRESS_THRESHOLD: press_thr  = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_taken) expected_presses.push_back(predict_press(touch_x, touch_y));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_presses.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected result play_state %0d press_fired %0d hit_now %0d",
                   $time, play_state, press_fired, hit_now);
        end else begin
          want = expected_presses.pop_front();
          if (play_state !== want.mode || press_fired !== want.fired ||
              hit_now !== want.hit) begin
            mismatch_count++;
            $display({"%0t expected play_state %0d press_fired %0d hit_now %0d,",
                      " actual %0d %0d %0d"},
                     $time, want.mode, want.fired, want.hit, play_state, press_fired, hit_now);
          end
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic queue_touch(int x, int y);
    touch_sample_t s;
    s.x = COORD_W'(x);
    s.y = COORD_W'(y);
    touch_pending.push_back(s);
    items_queued++;
  endtask

  task automatic drain_results();
    while (results_seen != items_queued) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_idling(int send_pct, int stall_pct);
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    @(negedge clk);
  endtask

  function automatic int pick_inside(int lo, int hi);
    if (hi > lo + 1) return $urandom_range(hi - 1, lo + 1);
    return $urandom_range(COORD_MAX);
  endfunction

  function automatic int pick_outside(int lo, int hi);
    case ($urandom_range(3))
      0:       return lo;
      1:       return hi;
      2:       return $urandom_range(lo);
      default: return $urandom_range(COORD_MAX, hi);
    endcase
  endfunction

  task automatic load_random_settings();
    int lo_x, hi_x, lo_y, hi_y, thr;
    logic [COORD_W-1:0] thr_data;
    case ($urandom_range(9))
      0: begin
        lo_x = 0; hi_x = COORD_MAX; lo_y = 0; hi_y = COORD_MAX;
      end
      1: begin
        lo_x = $urandom_range(COORD_MAX, 1);
        hi_x = $urandom_range(lo_x);
        lo_y = $urandom_range(COORD_MAX);
        hi_y = $urandom_range(COORD_MAX);
      end
      2: begin
        lo_x = $urandom_range(COORD_MAX - 2);
        hi_x = lo_x + 2;
        lo_y = $urandom_range(COORD_MAX - 2);
        hi_y = lo_y + 2;
      end
      default: begin
        lo_x = $urandom_range(900);
        hi_x = $urandom_range(COORD_MAX, lo_x + 2);
        lo_y = $urandom_range(900);
        hi_y = $urandom_range(COORD_MAX, lo_y + 2);
      end
    endcase
    case ($urandom_range(9))
      0:       thr = 0;
      1:       thr = $urandom_range(7, WINDOW_LEN + 1);
      default: thr = $urandom_range(WINDOW_LEN, 1);
    endcase
    thr_data = COORD_W'($urandom);
    thr_data[THR_W-1:0] = THR_W'(thr);
    cfg_write(REG_RECT_LEFT, COORD_W'(lo_x));
    cfg_write(REG_RECT_RIGHT, COORD_W'(hi_x));
    cfg_write(REG_RECT_TOP, COORD_W'(lo_y));
    cfg_write(REG_RECT_BOTTOM, COORD_W'(hi_y));
    cfg_write(REG_PRESS_THRESHOLD, thr_data);
    if ($urandom_range(2) == 0)
      cfg_write(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, int'(REG_PRESS_THRESHOLD) + 1)),
                COORD_W'($urandom));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // bursts of hits followed by misses, with some pure noise
  task automatic queue_random_touches(int n);
    int made, run, lo_x, hi_x, lo_y, hi_y;
    lo_x = int'(btn_left);
    hi_x = int'(btn_right);
    lo_y = int'(btn_top);
    hi_y = int'(btn_bottom);
    made = 0;
    while (made < n) begin
      if ($urandom_range(99) < 15) begin
        queue_touch($urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
        made++;
      end else begin
        run = $urandom_range(6, 1);
        repeat (run) queue_touch(pick_inside(lo_x, hi_x), pick_inside(lo_y, hi_y));
        made += run;
        run = $urandom_range(6);
        repeat (run) begin
          if ($urandom_range(1))
            queue_touch(pick_outside(lo_x, hi_x), pick_inside(lo_y, hi_y));
          else
            queue_touch(pick_inside(lo_x, hi_x), pick_outside(lo_y, hi_y));
        end
        made += run;
      end
    end
  endtask

  initial begin
    logic [COORD_W-1:0] thr_data;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default rectangle, presses through all play states and hold-off
    queue_touch(0, 0);
    queue_touch(COORD_MAX, COORD_MAX);
    queue_touch(1, 1);
    queue_touch(64, 64);
    queue_touch(32, 32);
    queue_touch(65, 32);
    queue_touch(32, 65);
    queue_touch(0, 32);
    queue_touch(32, 0);
    queue_touch(10, 10);
    repeat (6) queue_touch(20, 20);
    drain_results();

    // threshold zero with upper data bits set, unused indexes ignored
    thr_data = '1;
    thr_data[THR_W-1:0] = '0;
    cfg_write(REG_PRESS_THRESHOLD, thr_data);
    for (int i = int'(REG_PRESS_THRESHOLD) + 1; i < 2**CFG_IDX_W; i++)
      cfg_write(CFG_IDX_W'(i), '1);
    cfg_valid <= 1'b0;
    @(negedge clk);
    queue_touch(COORD_MAX, 0);
    queue_touch(0, COORD_MAX);
    queue_touch(512, 512);
    queue_touch(COORD_MAX, COORD_MAX);
    queue_touch(0, 0);
    drain_results();

    // empty rectangle in both axes, threshold above the window
    cfg_write(REG_RECT_LEFT, COORD_W'(500));
    cfg_write(REG_RECT_RIGHT, COORD_W'(500));
    cfg_write(REG_RECT_TOP, COORD_W'(700));
    cfg_write(REG_RECT_BOTTOM, COORD_W'(300));
    cfg_write(REG_PRESS_THRESHOLD, COORD_W'(7));
    cfg_valid <= 1'b0;
    @(negedge clk);
    queue_touch(500, 500);
    queue_touch(501, 400);
    queue_touch(499, 701);
    drain_results();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0:       set_idling(0, 0);
        1:       set_idling(86, 0);
        2:       set_idling(0, 86);
        default: set_idling(20, 20);
      endcase
      load_random_settings();
      queue_random_touches(190);
      drain_results();
    end

    if (expected_presses.size() != 0)
      $display("%0t %0d expected results never arrived", $time, expected_presses.size());
    if (mismatch_count == 0 && expected_presses.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tbwd_pkg.sv
rtl/tbwd_cfg.sv
rtl/tbwd_hit.sv
rtl/tbwd_vote.sv
rtl/touch_button_window_debounce.sv
verif/touch_button_window_debounce_tb.sv
